// File: design/led_flash_breathe_easing_assert.svh
// ----------------------------------------------------------------------------
// led_flash_breathe_easing assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LED_FLASH_BREATHE_EASING_ASSERT_SVH
`define LED_FLASH_BREATHE_EASING_ASSERT_SVH

`ifndef SYNTH
`define LFBE_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfbe assertion failed");
`define LFBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfbe assertion failed");
`else
`define LFBE_ASSERT(label, ante, cons)
`define LFBE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/lfbe_pkg.sv
// ----------------------------------------------------------------------------
// lfbe_pkg
// shared types, codes and control store for the led flash/breathe generator
// ----------------------------------------------------------------------------
`default_nettype none

package lfbe_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int UPC_W         = 4;
    localparam logic [15:0] LEVEL_MAX = 16'hFFFF;
    localparam logic [15:0] SPAN_MIN  = 16'd1;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_FLASH   = 2'd1,
        FUNC_BREATHE = 2'd2,
        FUNC_OFF     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_FLASH   = 2'd1,
        MODE_BREATHE = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] hue;
        logic [15:0] span_ticks;
    } in_word_t;

    typedef struct packed {
        logic [15:0] brightness;
        logic [15:0] hue_out;
        logic [1:0]  effect;
        logic        rising;
    } out_word_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_LOAD_FLASH,
        UOP_LOAD_BREATHE,
        UOP_DIV,
        UOP_MUL_XX,
        UOP_MUL_VX,
        UOP_MUL_VV,
        UOP_V_SHR,
        UOP_V_SHR1,
        UOP_V_ONE_MINUS_X,
        UOP_V_ONE_MINUS_E,
        UOP_FIN_FLASH,
        UOP_FIN_BREATHE
    } uop_t;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_LOOP,
        JC_HALF
    } jcond_t;

    typedef struct packed {
        uop_t             uop;
        jcond_t           jc;
        logic [UPC_W-1:0] target;
        logic             last;
    } ctrl_word_t;

    typedef struct packed {
        logic go;
        logic flash;
    } seq_start_t;

    typedef struct packed {
        logic busy;
        logic done;
    } seq_stat_t;

    localparam logic [UPC_W-1:0] ENTRY_FLASH   = 4'd0;
    localparam logic [UPC_W-1:0] UPC_FL_DIV    = 4'd1;
    localparam logic [UPC_W-1:0] ENTRY_BREATHE = 4'd7;
    localparam logic [UPC_W-1:0] UPC_BR_DIV    = 4'd8;
    localparam logic [UPC_W-1:0] UPC_BR_LOW    = 4'd13;
    localparam logic [UPC_W-1:0] UPC_BR_FIN    = 4'd15;

    function automatic ctrl_word_t lfbe_ucode(input logic [UPC_W-1:0] upc);
        ctrl_word_t cw;
        cw = '{uop: UOP_NOP, jc: JC_NONE, target: ENTRY_FLASH, last: 1'b0};
        unique case (upc)
            4'd0:  cw.uop = UOP_LOAD_FLASH;
            4'd1:  cw = '{uop: UOP_DIV, jc: JC_LOOP, target: UPC_FL_DIV, last: 1'b0};
            4'd2:  cw.uop = UOP_MUL_XX;
            4'd3:  cw.uop = UOP_V_SHR;
            4'd4:  cw.uop = UOP_MUL_VX;
            4'd5:  cw.uop = UOP_V_SHR;
            4'd6:  cw = '{uop: UOP_FIN_FLASH, jc: JC_NONE, target: ENTRY_FLASH, last: 1'b1};
            4'd7:  cw.uop = UOP_LOAD_BREATHE;
            4'd8:  cw = '{uop: UOP_DIV, jc: JC_LOOP, target: UPC_BR_DIV, last: 1'b0};
            4'd9:  cw = '{uop: UOP_NOP, jc: JC_HALF, target: UPC_BR_LOW, last: 1'b0};
            4'd10: cw.uop = UOP_V_ONE_MINUS_X;
            4'd11: cw.uop = UOP_MUL_VV;
            4'd12: cw = '{uop: UOP_V_ONE_MINUS_E, jc: JC_ALWAYS, target: UPC_BR_FIN,
                          last: 1'b0};
            4'd13: cw.uop = UOP_MUL_XX;
            4'd14: cw.uop = UOP_V_SHR1;
            4'd15: cw = '{uop: UOP_FIN_BREATHE, jc: JC_NONE, target: ENTRY_FLASH, last: 1'b1};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// File: design/led_flash_breathe_easing.sv
// ----------------------------------------------------------------------------
// led_flash_breathe_easing
// led flash and breathe effect generator stepped by frame ticks
// a flash or breathe tick runs up to FRAC_BITS+7 microcode steps (one fewer in
// the first half of a breathe span), FRAC_BITS+1 of them restoring divide steps
// input words stall while a tick runs and until its result word moves into the
// output register, so one word is in flight; that register holds its word
// under result_stall. async active-low reset: effect off, level 0
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_flash_breathe_easing_assert.svh"

module led_flash_breathe_easing #(
    parameter int FRAC_BITS = lfbe_pkg::FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire lfbe_pkg::in_word_t  item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output lfbe_pkg::out_word_t      result
);
    import lfbe_pkg::*;

    logic       accept;
    logic       need_run;
    logic       move;
    logic       pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;
    out_word_t  out_word_reg;
    seq_start_t start;
    seq_stat_t  stat;
    uop_t       uop;
    logic       half;
    mode_t      mode;
    out_word_t  snap;
    logic       busy;

    assign busy       = stat.busy;
    assign item_stall = busy || pend_reg;
    assign accept     = item_valid && !item_stall;
    assign need_run   = (item.func == FUNC_TICK) && (mode != MODE_NONE);
    assign start.go    = accept && need_run;
    assign start.flash = (mode == MODE_FLASH);
    assign move       = pend_reg && (!out_valid_reg || !result_stall);

    lfbe_seq #(
        .FRAC_BITS(FRAC_BITS)
    ) u_seq (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .half (half),
        .uop  (uop),
        .stat (stat)
    );

    lfbe_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .load (accept && !need_run),
        .item (item),
        .uop  (uop),
        .half (half),
        .mode (mode),
        .snap (snap)
    );

    always_comb
    begin
        pend_next = pend_reg;
        if (move)
            pend_next = 1'b0;
        else if ((accept && !need_run) || stat.done)
            pend_next = 1'b1;

        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
            out_word_reg <= snap;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    `LFBE_ASSERT_NEXT(a_accept_tracked, accept, busy || pend_reg)
    `LFBE_ASSERT(a_pend_idle, pend_reg, !busy)
    `LFBE_ASSERT(a_done_pends, $fell(busy), pend_reg)

endmodule

`default_nettype wire

// File: design/lfbe_seq.sv
// ----------------------------------------------------------------------------
// lfbe_seq
// microcode sequencer: step counter, divide loop counter and jump logic
// ----------------------------------------------------------------------------
`default_nettype none

module lfbe_seq #(
    parameter int FRAC_BITS = lfbe_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lfbe_pkg::seq_start_t start,
    input  wire logic               half,
    output lfbe_pkg::uop_t          uop,
    output lfbe_pkg::seq_stat_t     stat
);
    import lfbe_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic             run_reg, run_next;
    logic [UPC_W-1:0] upc_reg, upc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    ctrl_word_t       cw;
    logic             taken;

    assign cw = lfbe_ucode(upc_reg);

    always_comb
    begin
        unique case (cw.jc)
            JC_NONE:   taken = 1'b0;
            JC_ALWAYS: taken = 1'b1;
            JC_LOOP:   taken = (cnt_reg != '0);
            JC_HALF:   taken = half;
        endcase
    end

    // next state
    always_comb
    begin
        run_next = run_reg;
        upc_next = upc_reg;
        cnt_next = cnt_reg;
        if (start.go)
        begin
            run_next = 1'b1;
            upc_next = start.flash ? ENTRY_FLASH : ENTRY_BREATHE;
        end
        else if (run_reg)
        begin
            if (cw.last)
                run_next = 1'b0;
            upc_next = taken ? cw.target : upc_reg + 1'b1;
            if (cw.uop == UOP_LOAD_FLASH || cw.uop == UOP_LOAD_BREATHE)
                cnt_next = CNT_W'(FRAC_BITS);
            else if (cw.uop == UOP_DIV && cnt_reg != '0)
                cnt_next = cnt_reg - 1'b1;
        end
    end

    // outputs
    always_comb
    begin
        uop       = run_reg ? cw.uop : UOP_NOP;
        stat.busy = run_reg;
        stat.done = run_reg && cw.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            upc_reg <= ENTRY_FLASH;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: design/lfbe_dp.sv
// ----------------------------------------------------------------------------
// lfbe_dp
// effect state, restoring divider step, shared multiplier and level shaping
// ----------------------------------------------------------------------------
`default_nettype none

module lfbe_dp #(
    parameter int FRAC_BITS = lfbe_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire lfbe_pkg::in_word_t item,
    input  wire lfbe_pkg::uop_t     uop,
    output logic                    half,
    output lfbe_pkg::mode_t         mode,
    output lfbe_pkg::out_word_t     snap
);
    import lfbe_pkg::*;

    localparam int W   = FRAC_BITS + 2;
    localparam int PW  = 2 * W;
    localparam int QW  = W + 16;
    localparam int SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    mode_t       mode_reg, mode_next;
    logic [15:0] hue_reg, hue_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [15:0] span_reg, span_next;
    logic        up_reg, up_next;
    logic [15:0] level_reg, level_next;

    logic [16:0]   rem_reg, rem_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  v_reg, v_next;
    logic [PW-1:0] p_reg, p_next;
    logic          half_reg, half_next;

    logic [15:0]   sp;
    logic [15:0]   tick_inc;
    logic          ge;
    logic [16:0]   diff;
    logic [16:0]   kept;
    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] prod;
    logic [PW-1:0] e_wide;
    logic [W-1:0]  y_sel;
    logic [QW-1:0] q_wide;
    logic [15:0]   level_q;

    assign sp       = (item.span_ticks == '0) ? SPAN_MIN : item.span_ticks;
    assign tick_inc = tick_count_reg + 16'd1;
    assign ge       = rem_reg >= {1'b0, span_reg};
    assign diff     = rem_reg - {1'b0, span_reg};
    assign kept     = ge ? diff : rem_reg;
    assign e_wide   = p_reg >> (FRAC_BITS - 1);

    always_comb
    begin
        unique case (uop)
            UOP_MUL_VX:
            begin
                mul_a = v_reg;
                mul_b = x_reg;
            end
            UOP_MUL_VV:
            begin
                mul_a = v_reg;
                mul_b = v_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
        endcase
        prod = PW'(mul_a) * PW'(mul_b);
    end

    always_comb
    begin
        y_sel = v_reg;
        if (uop == UOP_FIN_BREATHE && !up_reg)
            y_sel = ONE - v_reg;
        q_wide  = (QW'(y_sel) >> SHR) << SHL;
        level_q = (q_wide > QW'(LEVEL_MAX)) ? LEVEL_MAX : q_wide[15:0];
    end

    always_comb
    begin
        mode_next       = mode_reg;
        hue_next        = hue_reg;
        tick_count_next = tick_count_reg;
        span_next       = span_reg;
        up_next         = up_reg;
        level_next      = level_reg;
        rem_next        = rem_reg;
        x_next          = x_reg;
        v_next          = v_reg;
        p_next          = p_reg;
        half_next       = half_reg;

        unique case (uop)
            UOP_LOAD_FLASH:
            begin
                rem_next = (tick_count_reg < span_reg)
                         ? {1'b0, span_reg - tick_count_reg} : '0;
                x_next   = '0;
            end
            UOP_LOAD_BREATHE:
            begin
                rem_next  = {1'b0, tick_count_reg};
                x_next    = '0;
                half_next = {tick_count_reg, 1'b0} < {1'b0, span_reg};
            end
            UOP_DIV:
            begin
                rem_next = {kept[15:0], 1'b0};
                x_next   = {x_reg[W-2:0], ge};
            end
            UOP_MUL_XX, UOP_MUL_VX, UOP_MUL_VV:
                p_next = prod;
            UOP_V_SHR:
                v_next = W'(p_reg >> FRAC_BITS);
            UOP_V_SHR1:
                v_next = W'(e_wide);
            UOP_V_ONE_MINUS_X:
                v_next = ONE - x_reg;
            UOP_V_ONE_MINUS_E:
                v_next = (e_wide > PW'(ONE)) ? '0 : ONE - W'(e_wide);
            UOP_FIN_FLASH:
            begin
                level_next      = level_q;
                tick_count_next = tick_inc;
                if (tick_inc >= span_reg)
                begin
                    mode_next  = MODE_NONE;
                    level_next = '0;
                end
            end
            UOP_FIN_BREATHE:
            begin
                level_next      = level_q;
                tick_count_next = tick_inc;
                if (tick_inc >= span_reg)
                begin
                    tick_count_next = '0;
                    up_next         = !up_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (load)
        begin
            unique case (item.func)
                FUNC_FLASH:
                begin
                    mode_next       = MODE_FLASH;
                    hue_next        = item.hue;
                    tick_count_next = '0;
                    span_next       = sp;
                end
                FUNC_BREATHE:
                begin
                    mode_next       = MODE_BREATHE;
                    hue_next        = item.hue;
                    tick_count_next = '0;
                    span_next       = sp;
                    up_next         = 1'b1;
                end
                FUNC_OFF:
                begin
                    mode_next  = MODE_NONE;
                    level_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NONE;
            hue_reg        <= '0;
            tick_count_reg <= '0;
            span_reg       <= SPAN_MIN;
            up_reg         <= 1'b1;
            level_reg      <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            hue_reg        <= hue_next;
            tick_count_reg <= tick_count_next;
            span_reg       <= span_next;
            up_reg         <= up_next;
            level_reg      <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        x_reg    <= x_next;
        v_reg    <= v_next;
        p_reg    <= p_next;
        half_reg <= half_next;
    end

    assign half            = half_reg;
    assign mode            = mode_reg;
    assign snap.brightness = level_reg;
    assign snap.hue_out    = hue_reg;
    assign snap.effect     = mode_reg;
    assign snap.rising     = up_reg;

endmodule

`default_nettype wire

// File: bench/lfbe_checker.sv
// ----------------------------------------------------------------------------
// lfbe_checker
// watches both channels of the led flash/breathe generator, keeps its own
// copy of the effect state, predicts every result word and compares it
// field by field with what the block returns
// ----------------------------------------------------------------------------
module lfbe_checker #(
    parameter int FRAC_BITS = lfbe_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  lfbe_pkg::in_word_t  item,
    input  logic                result_valid,
    input  logic                result_stall,
    input  lfbe_pkg::out_word_t result,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lfbe_pkg::*;

    localparam logic [63:0] ONE_FX  = 64'd1 << FRAC_BITS;
    localparam int          SHR_Q16 = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int          SHL_Q16 = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    mode_t       cur_mode;
    logic [15:0] cur_hue;
    logic [15:0] cur_count;
    logic [15:0] cur_span;
    logic [15:0] cur_level;
    logic        cur_up;

    out_word_t   led_states_due[$];
    int          errors;
    int          waiting;

    assign fail_count = errors;
    assign pending    = waiting;

    function automatic logic [63:0] frac_ratio(input logic [15:0] num, input logic [15:0] den);
        return ({48'd0, num} << FRAC_BITS) / {48'd0, den};
    endfunction

    function automatic logic [15:0] to_level(input logic [63:0] v);
        logic [63:0] q;
        q = (v >> SHR_Q16) << SHL_Q16;
        return (q > 64'hFFFF) ? LEVEL_MAX : q[15:0];
    endfunction

    function automatic out_word_t step_led(input in_word_t w);
        logic [15:0] sp;
        logic [15:0] t;
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] r3;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] d;
        logic [63:0] e;
        sp = (w.span_ticks == 16'd0) ? SPAN_MIN : w.span_ticks;
        t  = cur_count;
        case (func_t'(w.func))
            FUNC_TICK:
            begin
                if (cur_mode == MODE_FLASH)
                begin
                    r  = frac_ratio((t < cur_span) ? cur_span - t : 16'd0, cur_span);
                    r2 = (r * r) >> FRAC_BITS;
                    r3 = (r2 * r) >> FRAC_BITS;
                    cur_level = to_level(r3);
                    cur_count = t + 16'd1;
                    if (cur_count >= cur_span)
                    begin
                        cur_mode  = MODE_NONE;
                        cur_level = 16'd0;
                    end
                end
                else if (cur_mode == MODE_BREATHE)
                begin
                    x = frac_ratio(t, cur_span);
                    if (x > ONE_FX)
                        x = ONE_FX;
                    if (({1'b0, t} << 1) < {1'b0, cur_span})
                    begin
                        y = (64'd2 * x * x) >> FRAC_BITS;
                    end
                    else
                    begin
                        d = ONE_FX - x;
                        e = (64'd2 * d * d) >> FRAC_BITS;
                        y = (e > ONE_FX) ? 64'd0 : ONE_FX - e;
                    end
                    if (!cur_up)
                        y = ONE_FX - y;
                    cur_level = to_level(y);
                    cur_count = t + 16'd1;
                    if (cur_count >= cur_span)
                    begin
                        cur_count = 16'd0;
                        cur_up    = ~cur_up;
                    end
                end
            end
            FUNC_FLASH:
            begin
                cur_mode  = MODE_FLASH;
                cur_hue   = w.hue;
                cur_count = 16'd0;
                cur_span  = sp;
            end
            FUNC_BREATHE:
            begin
                cur_mode  = MODE_BREATHE;
                cur_hue   = w.hue;
                cur_count = 16'd0;
                cur_span  = sp;
                cur_up    = 1'b1;
            end
            default:
            begin
                cur_mode  = MODE_NONE;
                cur_level = 16'd0;
            end
        endcase
        return '{brightness: cur_level, hue_out: cur_hue, effect: cur_mode, rising: cur_up};
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            cur_mode  = MODE_NONE;
            cur_hue   = 16'd0;
            cur_count = 16'd0;
            cur_span  = SPAN_MIN;
            cur_up    = 1'b1;
            cur_level = 16'd0;
            led_states_due.delete();
            errors    = 0;
            waiting   = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                led_states_due.push_back(step_led(item));
            if (result_valid && !result_stall)
            begin
                if (led_states_due.size() == 0)
                begin
                    $display("%0t ns: unexpected result word, expected none actual %h",
                             $time, result);
                    errors++;
                end
                else
                begin
                    want = led_states_due.pop_front();
                    check_field("brightness", want.brightness, result.brightness);
                    check_field("hue_out", want.hue_out, result.hue_out);
                    check_field("effect", 16'(want.effect), 16'(result.effect));
                    check_field("rising", 16'(want.rising), 16'(result.rising));
                end
            end
            waiting = led_states_due.size();
        end
    end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the led flash/breathe generator: a directed run
// over zero and full spans, direction flips and off/tick corner cases, then
// random flash and breathe sequences with idle bursts on both channels
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lfbe_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_word_t  item;
    logic      result_valid;
    logic      result_stall;
    out_word_t result;
    int        fail_count;
    int        pending;
    bit        idle_on;
    int        sent;

    led_flash_breathe_easing i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    lfbe_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // entered and left at a falling edge
    task automatic send_word(input func_t f, input logic [15:0] h, input logic [15:0] s);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{func: f, hue: h, span_ticks: s};
        do
            @(posedge clk);
        while (item_stall);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int stall_left;
        result_stall = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (idle_on && stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                stall_left = $urandom_range(1, 13) - 1;
            end
            else
            begin
                result_stall <= 1'b0;
                stall_left = 0;
            end
        end
    end

    initial
    begin
        int          targets[4];
        bit          idles[4];
        int          nt;
        int          lim;
        logic [15:0] sp;
        func_t       fs;
        targets    = '{200, 350, 700, 800};
        idles      = '{1'b1, 1'b0, 1'b1, 1'b0};
        item_valid = 1'b0;
        item       = '0;
        rst_n      = 1'b0;
        idle_on    = 1'b0;
        sent       = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle tick and off straight after reset
        send_word(FUNC_TICK, 16'hFFFF, 16'hFFFF);
        send_word(FUNC_OFF, 16'hA5A5, 16'h0000);
        // zero span flash ends on its first tick
        send_word(FUNC_FLASH, 16'hFFFF, 16'h0000);
        send_word(FUNC_TICK, 16'h0000, 16'h0000);
        send_word(FUNC_FLASH, 16'h1234, 16'd3);
        repeat (4) send_word(FUNC_TICK, 16'h5555, 16'hAAAA);
        // breathe with span one flips every tick
        send_word(FUNC_BREATHE, 16'h0000, 16'h0000);
        repeat (2) send_word(FUNC_TICK, 16'h0000, 16'h0000);
        send_word(FUNC_BREATHE, 16'h8001, 16'd4);
        repeat (5) send_word(FUNC_TICK, 16'h0F0F, 16'hF0F0);
        // off and flash keep the falling direction
        send_word(FUNC_OFF, 16'hFFFF, 16'hFFFF);
        send_word(FUNC_TICK, 16'hFFFF, 16'h0001);
        send_word(FUNC_FLASH, 16'h7FFE, 16'hFFFF);
        repeat (2) send_word(FUNC_TICK, 16'h0000, 16'h0000);
        send_word(FUNC_BREATHE, 16'h00FF, 16'hFFFF);
        send_word(FUNC_TICK, 16'h0000, 16'h0000);
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            idle_on = idles[p];
            while (sent < targets[p])
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    case ($urandom_range(0, 19))
                        0:       sp = 16'd0;
                        1:       sp = 16'($urandom);
                        2, 3, 4: sp = 16'($urandom_range(13, 64));
                        default: sp = 16'($urandom_range(1, 12));
                    endcase
                    lim = (sp == 16'd0) ? 1 : ((sp > 16'd40) ? 40 : int'(sp));
                    fs  = $urandom_range(0, 1) ? FUNC_FLASH : FUNC_BREATHE;
                    nt  = (fs == FUNC_FLASH) ? $urandom_range(0, lim + 2)
                                             : $urandom_range(0, 3 * lim + 1);
                    send_word(fs, 16'($urandom), sp);
                    repeat (nt) send_word(FUNC_TICK, 16'($urandom), 16'($urandom));
                    if ($urandom_range(0, 3) == 0)
                        send_word(FUNC_OFF, 16'($urandom), 16'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_word(func_t'($urandom_range(0, 3)), 16'($urandom),
                                  16'($urandom));
                end
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
            drain_results();
        end

        repeat (60) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("led_flash_breathe_easing verification clean");
        else
            $display("led_flash_breathe_easing verification failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("led_flash_breathe_easing verification failed");
        $finish;
    end

endmodule
